FILE: src/assert_macros.svh
// Assertion shorthands used by the checker file, mf3_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is applied.
`define MF3_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define MF3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/mf3_pkg.sv
package mf3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int PIXEL_BITS = 8;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int EW_W     = COL_W + 1;
  localparam int ROW_W    = 12;
  localparam int FW_W     = 11;
  localparam int FH_W     = 13;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  typedef logic [PIXEL_BITS-1:0] pixel_t;

  // Per-pixel bookkeeping that travels with a pixel down the pipeline.
  typedef struct packed {
    logic             emit;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             done;
  } meta_t;

  // Contents of the stage between the line store read and the window.
  typedef struct packed {
    pixel_t           pixel;
    logic [COL_W-1:0] addr;
    meta_t            meta;
  } stage_t;

endpackage

FILE: src/median_filter_3x3_top.sv
// Streaming 3x3 median filter: pixels enter in raster order, one per transfer,
// and for every interior position the block returns the median of its nine
// neighbors together with the row and column of that position; border
// positions produce no transfer and are left to the consumer. The result for
// position (r, c) leaves after pixel (r+1, c+1) has been taken, and
// out_frame_done marks the last interior pixel of the frame. Throughput is
// one pixel per clock while out_ready does not stall the pipeline; it is
// set by the two line stores, each a single 1024 x 8 memory with one read
// and one write per pixel, and successive pixels always touch different
// columns so no forwarding is needed. Up to five pixels are held in flight,
// so input keeps flowing until the pipeline is full while a finished result
// waits for the consumer. The line stores need no clearing after reset.
// The user must write frame width (register 0) and height (register 1) on
// the cfg channel only while the block is idle; the block does not enforce
// it. Values out of range are clamped to 3..1024 and 3..4096.
module median_filter_3x3_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mf3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mf3_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  mf3_pkg::pixel_t                in_pixel_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output mf3_pkg::pixel_t                out_median_out,
  output logic [mf3_pkg::ROW_W-1:0]      out_row,
  output logic [mf3_pkg::COL_W-1:0]      out_col,
  output logic                           out_frame_done
);
  import mf3_pkg::*;

  // First stage: the pixel just transferred, its column address and the
  // output decision, waiting for the line store read data.
  logic             s1_valid;
  logic             s1_take;
  stage_t           s1;
  logic             rd_en;
  logic [COL_W-1:0] rd_addr;
  pixel_t           rd_top;
  pixel_t           rd_mid;
  logic             wr_en;

  mf3_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_pixel_in (in_pixel_in),
    .s1_take     (s1_take),
    .s1_valid    (s1_valid),
    .s1          (s1),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr)
  );

  // When a pixel moves into the window, its column is rewritten: the middle
  // row word moves up and the new pixel becomes the middle row.
  assign wr_en = s1_valid && s1_take;

  mf3_line_store u_line_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (s1.addr),
    .wr_top  (rd_mid),
    .wr_mid  (s1.pixel),
    .rd_top  (rd_top),
    .rd_mid  (rd_mid)
  );

  mf3_median u_median (
    .clk            (clk),
    .rst_n          (rst_n),
    .s1_valid       (s1_valid),
    .s1             (s1),
    .rd_top         (rd_top),
    .rd_mid         (rd_mid),
    .s1_take        (s1_take),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_median_out (out_median_out),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_frame_done (out_frame_done)
  );

endmodule

FILE: src/mf3_line_store.sv
module mf3_line_store (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [mf3_pkg::COL_W-1:0] rd_addr,
  input  logic                     wr_en,
  input  logic [mf3_pkg::COL_W-1:0] wr_addr,
  input  mf3_pkg::pixel_t          wr_top,
  input  mf3_pkg::pixel_t          wr_mid,
  output mf3_pkg::pixel_t          rd_top,
  output mf3_pkg::pixel_t          rd_mid
);
  import mf3_pkg::*;

  pixel_t upper_mem [MAX_WIDTH];
  pixel_t middle_mem [MAX_WIDTH];
  pixel_t rd_top_r;
  pixel_t rd_mid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= wr_top;
      middle_mem[wr_addr] <= wr_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_top_r <= upper_mem[rd_addr];
      rd_mid_r <= middle_mem[rd_addr];
    end
  end

  assign rd_top = rd_top_r;
  assign rd_mid = rd_mid_r;

endmodule

FILE: src/mf3_scan.sv
module mf3_scan (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mf3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mf3_pkg::CFG_W-1:0]     cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  mf3_pkg::pixel_t              in_pixel_in,
  input  logic                         s1_take,
  output logic                         s1_valid,
  output mf3_pkg::stage_t              s1,
  output logic                         rd_en,
  output logic [mf3_pkg::COL_W-1:0]     rd_addr
);
  import mf3_pkg::*;

  logic [FW_W-1:0]  frame_width_r;
  logic [FH_W-1:0]  frame_height_r;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             s1_valid_r;
  stage_t           s1_r;
  logic [EW_W-1:0]  w_eff;
  logic [FH_W-1:0]  h_eff;
  logic [EW_W-1:0]  col_ext;
  logic [FH_W-1:0]  row_ext;
  logic             last_col;
  logic             accept;
  meta_t            meta;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FW_W'(MAX_WIDTH);
      frame_height_r <= FH_W'(1024);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // Out-of-range sizes are clamped to the supported range.
  always_comb begin
    if (frame_width_r < FW_W'(3)) begin
      w_eff = EW_W'(3);
    end else if (int'(frame_width_r) > MAX_WIDTH) begin
      w_eff = EW_W'(MAX_WIDTH);
    end else begin
      w_eff = EW_W'(frame_width_r);
    end
    if (frame_height_r < FH_W'(3)) begin
      h_eff = FH_W'(3);
    end else if (int'(frame_height_r) > MAX_HEIGHT) begin
      h_eff = FH_W'(MAX_HEIGHT);
    end else begin
      h_eff = frame_height_r;
    end
  end

  assign col_ext  = EW_W'(col_r);
  assign row_ext  = FH_W'(row_r);
  assign last_col = col_ext >= (w_eff - EW_W'(1));

  always_comb begin
    meta.emit = (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2)) &&
                (row_ext < h_eff) && (col_ext < w_eff);
    meta.row  = row_r - ROW_W'(1);
    meta.col  = col_r - COL_W'(1);
    meta.done = (row_ext == h_eff - FH_W'(1)) && (col_ext == w_eff - EW_W'(1));
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = (row_ext >= h_eff - FH_W'(1)) ? '0 : row_r + ROW_W'(1);
    end else begin
      col_nxt = col_r + COL_W'(1);
    end
  end

  assign in_ready = !s1_valid_r || s1_take;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r.pixel <= in_pixel_in;
      s1_r.addr  <= col_r;
      s1_r.meta  <= meta;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;
  assign rd_en    = accept;
  assign rd_addr  = col_r;

endmodule

FILE: src/mf3_median.sv
module mf3_median (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           s1_valid,
  input  mf3_pkg::stage_t                s1,
  input  mf3_pkg::pixel_t                rd_top,
  input  mf3_pkg::pixel_t                rd_mid,
  output logic                           s1_take,
  output logic                           out_valid,
  input  logic                           out_ready,
  output mf3_pkg::pixel_t                out_median_out,
  output logic [mf3_pkg::ROW_W-1:0]      out_row,
  output logic [mf3_pkg::COL_W-1:0]      out_col,
  output logic                           out_frame_done
);
  import mf3_pkg::*;

  typedef struct packed {
    pixel_t lo;
    pixel_t md;
    pixel_t hi;
  } trio_t;

  function automatic pixel_t min2(input pixel_t a, input pixel_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pixel_t max2(input pixel_t a, input pixel_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pixel_t med3(input pixel_t a, input pixel_t b, input pixel_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic trio_t sort3(input pixel_t a, input pixel_t b, input pixel_t c);
    trio_t t;
    t.lo = min2(min2(a, b), c);
    t.hi = max2(max2(a, b), c);
    t.md = med3(a, b, c);
    return t;
  endfunction

  pixel_t win_r [9];
  trio_t  row_sort_r [3];
  pixel_t lo_max_r, md_med_r, hi_min_r;
  meta_t  meta2_r, meta3_r, meta4_r;
  logic   v2_r, v3_r, v4_r, out_valid_r;
  pixel_t median_r;
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_r;
  logic   done_r;
  logic   ready2, ready3, ready4, ready_o;

  assign ready_o = !out_valid_r || out_ready;
  assign ready4  = !v4_r || ready_o;
  assign ready3  = !v3_r || ready4;
  assign ready2  = !v2_r || ready3;
  assign s1_take = ready2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ready2) v2_r <= s1_valid && s1.meta.emit;
      if (ready3) v3_r <= v2_r;
      if (ready4) v4_r <= v3_r;
      if (ready_o) out_valid_r <= v4_r;
    end
  end

  // The window shifts one column per pixel; its rightmost column takes the
  // two line store words and the new pixel.
  always_ff @(posedge clk) begin
    if (s1_valid && ready2) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k*3]   <= win_r[k*3+1];
        win_r[k*3+1] <= win_r[k*3+2];
      end
      win_r[2] <= rd_top;
      win_r[5] <= rd_mid;
      win_r[8] <= s1.pixel;
      meta2_r  <= s1.meta;
    end
  end

  // Median of nine: sort rows, then take the median of the largest low,
  // the middle median and the smallest high.
  always_ff @(posedge clk) begin
    if (ready3) begin
      for (int k = 0; k < 3; k++) begin
        row_sort_r[k] <= sort3(win_r[k*3], win_r[k*3+1], win_r[k*3+2]);
      end
      meta3_r <= meta2_r;
    end
    if (ready4) begin
      lo_max_r <= max2(max2(row_sort_r[0].lo, row_sort_r[1].lo), row_sort_r[2].lo);
      md_med_r <= med3(row_sort_r[0].md, row_sort_r[1].md, row_sort_r[2].md);
      hi_min_r <= min2(min2(row_sort_r[0].hi, row_sort_r[1].hi), row_sort_r[2].hi);
      meta4_r  <= meta3_r;
    end
    if (ready_o) begin
      median_r <= med3(lo_max_r, md_med_r, hi_min_r);
      row_r    <= meta4_r.row;
      col_r    <= meta4_r.col;
      done_r   <= meta4_r.done;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_median_out = median_r;
  assign out_row        = row_r;
  assign out_col        = col_r;
  assign out_frame_done = done_r;

endmodule

FILE: src/mf3_checker.sv
`include "assert_macros.svh"

module mf3_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input mf3_pkg::pixel_t                out_median_out,
  input logic [mf3_pkg::ROW_W-1:0]      out_row,
  input logic [mf3_pkg::COL_W-1:0]      out_col,
  input logic                           out_frame_done
);
  import mf3_pkg::*;

  // All result fields side by side, so that one stability check covers them.
  logic [PIXEL_BITS+ROW_W+COL_W:0] out_fields;

  assign out_fields = {out_median_out, out_row, out_col, out_frame_done};

  `MF3_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `MF3_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_fields), "stalled result changed")
  `MF3_ASSERT_NOW(a_interior, out_valid, out_row != '0 && out_col != '0, "border position emitted")
  `MF3_ASSERT_NOW(a_drained_ready, !out_valid, in_ready, "input blocked with empty output")

endmodule

bind median_filter_3x3_top mf3_checker u_mf3_checker (.*);
